[sv/csq_pkg.sv]
// Shared codes and control types for the counting semaphore wait queue.
`default_nettype none

package csq_pkg;

   localparam int OPCODE_BITS = 3;
   localparam int STATUS_BITS = 3;
   localparam int CSR_BITS    = 16;

   localparam logic [OPCODE_BITS-1:0] OP_WAIT   = 3'd0;
   localparam logic [OPCODE_BITS-1:0] OP_SIGNAL = 3'd1;
   localparam logic [OPCODE_BITS-1:0] OP_EXPIRE = 3'd2;
   localparam logic [OPCODE_BITS-1:0] OP_RESUME = 3'd3;
   localparam logic [OPCODE_BITS-1:0] OP_INIT   = 3'd4;

   localparam logic [STATUS_BITS-1:0] ST_ACQUIRED  = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_QUEUED    = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_REFUSED   = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_WOKE      = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_RAISED    = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_TIMEOUT   = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_SIGNALLED = 3'd6;
   localparam logic [STATUS_BITS-1:0] ST_INIT      = 3'd7;

   // per-transfer command broadcast to every queue cell
   typedef struct packed {
      logic append;     // place requester at the tail
      logic need_live;  // search skips expired entries
      logic match_id;   // search compares against requester id
      logic shift;      // first hit is removed, later cells close the gap
      logic mark;       // first hit is marked expired
      logic clear;      // empty the queue
   } csq_ctrl_type;

endpackage

`default_nettype wire

[sv/csq_cell.sv]
// One wait queue slot: holds an entry and takes its neighbour's on removal.
`default_nettype none

module csq_cell #(
   parameter int ID_BITS = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire csq_pkg::csq_ctrl_type ctrl,
   input  wire logic [ID_BITS-1:0]   req_id,
   input  wire logic                 prev_valid,
   input  wire logic                 found_in,
   output logic                      found_out,
   input  wire logic                 next_valid,
   input  wire logic [ID_BITS-1:0]   next_id,
   input  wire logic                 next_expired,
   output logic                      valid,
   output logic [ID_BITS-1:0]        id,
   output logic                      expired,
   output logic [ID_BITS-1:0]        sel_id
);

   logic               valid_ff, valid_in;
   logic               expired_ff, expired_in;
   logic [ID_BITS-1:0] id_ff, id_in;
   logic               hit;
   logic               first;

   always_comb begin
      hit = (ctrl.shift | ctrl.mark) & valid_ff
            & (!ctrl.need_live | !expired_ff)
            & (!ctrl.match_id | (id_ff == req_id));
      first     = hit & !found_in;
      found_out = found_in | hit;
      sel_id    = first ? id_ff : '0;

      valid_in   = valid_ff;
      id_in      = id_ff;
      expired_in = expired_ff;
      if (ctrl.clear) begin
         valid_in   = 1'b0;
         expired_in = 1'b0;
      end else if (ctrl.shift && found_out) begin
         valid_in   = next_valid;
         id_in      = next_id;
         expired_in = next_expired;
      end else if (ctrl.mark && first) begin
         expired_in = 1'b1;
      end else if (ctrl.append && !valid_ff && prev_valid) begin
         valid_in   = 1'b1;
         id_in      = req_id;
         expired_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         expired_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         expired_ff <= expired_in;
      end
      id_ff <= id_in;
   end

   assign valid   = valid_ff;
   assign id      = id_ff;
   assign expired = expired_ff;

endmodule

`default_nettype wire

[sv/counting_semaphore_wait_queue.sv]
// Top level: semaphore count, queue cell row and registered response.
//
//  channel | dir | handshake            | payload
//  req     | in  | req_tvalid/tready    | tdata: opcode, requester_id
//  rsp     | out | rsp_tvalid/tready    | tdata: status, woken_id, count_now, queue_length
//  csr     | in  | csr_we               | csr_wdata: start_count
//
// One transfer per cycle while results are taken; the result is registered and appears in the
// cycle after acceptance. The search and compaction run across the row of MAX_WAITERS cells in the accepting cycle.
// Reset empties the queue and zeroes count and start_count.
// The request side stalls only while a held result is not taken.
`default_nettype none

module counting_semaphore_wait_queue #(
   parameter int MAX_WAITERS = 16,
   parameter int ID_BITS     = 8,
   parameter int COUNT_BITS  = 16,
   localparam int LEN_BITS   = $clog2(MAX_WAITERS + 1),
   localparam int REQ_BITS   = csq_pkg::OPCODE_BITS + ID_BITS,
   localparam int REQ_W      = ((REQ_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = csq_pkg::STATUS_BITS + ID_BITS + COUNT_BITS + LEN_BITS,
   localparam int RSP_W      = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [REQ_W-1:0]              req_tdata,   // opcode, requester_id
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   output logic [RSP_W-1:0]                   rsp_tdata,   // status, woken_id, count_now, queue_length
   input  wire logic                          csr_we,
   input  wire logic [csq_pkg::CSR_BITS-1:0]  csr_wdata
);

   logic [csq_pkg::OPCODE_BITS-1:0] opcode;
   logic [ID_BITS-1:0]              req_id;
   logic                            accept;

   logic [csq_pkg::CSR_BITS-1:0] csr_ff;
   logic [COUNT_BITS-1:0]        count_ff, count_in;
   logic [LEN_BITS-1:0]          total_ff, total_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]             rsp_data_ff, rsp_data_in;

   csq_pkg::csq_ctrl_type ctrl;
   logic [csq_pkg::STATUS_BITS-1:0] status;
   logic [ID_BITS-1:0]              woken;
   logic                            full;
   logic                            hit_any;

   logic [MAX_WAITERS:0]   found;
   logic [MAX_WAITERS:0]   cell_valid;
   logic [MAX_WAITERS:0]   cell_expired;
   logic [ID_BITS-1:0]     cell_id  [MAX_WAITERS+1];
   logic [ID_BITS-1:0]     cell_sel [MAX_WAITERS];
   logic [MAX_WAITERS-1:0] prev_valid;

   assign opcode     = req_tdata[csq_pkg::OPCODE_BITS-1:0];
   assign req_id     = req_tdata[csq_pkg::OPCODE_BITS +: ID_BITS];
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign full       = (total_ff == LEN_BITS'(MAX_WAITERS));

   // beyond the last cell: an empty slot
   assign found[0]                 = 1'b0;
   assign cell_valid[MAX_WAITERS]   = 1'b0;
   assign cell_expired[MAX_WAITERS] = 1'b0;
   assign cell_id[MAX_WAITERS]      = '0;
   assign hit_any                   = found[MAX_WAITERS];

   always_comb begin
      ctrl = '0;
      if (accept) begin
         unique case (opcode)
            csq_pkg::OP_WAIT:   ctrl.append = (count_ff == '0) && !full;
            csq_pkg::OP_SIGNAL: begin
               ctrl.need_live = 1'b1;
               ctrl.shift     = 1'b1;
            end
            csq_pkg::OP_EXPIRE: begin
               ctrl.need_live = 1'b1;
               ctrl.match_id  = 1'b1;
               ctrl.mark      = 1'b1;
            end
            csq_pkg::OP_RESUME: begin
               ctrl.match_id = 1'b1;
               ctrl.shift    = 1'b1;
            end
            csq_pkg::OP_INIT:   ctrl.clear = 1'b1;
            default:            ctrl = '0;
         endcase
      end
   end

   genvar g;
   generate
      for (g = 0; g < MAX_WAITERS; g++) begin : g_cell
         if (g == 0) begin : g_head
            assign prev_valid[g] = 1'b1;
         end else begin : g_body
            assign prev_valid[g] = cell_valid[g-1];
         end
         csq_cell #(
            .ID_BITS (ID_BITS)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .ctrl         (ctrl),
            .req_id       (req_id),
            .prev_valid   (prev_valid[g]),
            .found_in     (found[g]),
            .found_out    (found[g+1]),
            .next_valid   (cell_valid[g+1]),
            .next_id      (cell_id[g+1]),
            .next_expired (cell_expired[g+1]),
            .valid        (cell_valid[g]),
            .id           (cell_id[g]),
            .expired      (cell_expired[g]),
            .sel_id       (cell_sel[g])
         );
      end
   endgenerate

   // only a signal reports the id it took out
   always_comb begin
      woken = '0;
      for (int i = 0; i < MAX_WAITERS; i++) begin
         woken = woken | cell_sel[i];
      end
      if (opcode != csq_pkg::OP_SIGNAL) woken = '0;
   end

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      status   = csq_pkg::ST_REFUSED;
      unique case (opcode)
         csq_pkg::OP_WAIT: begin
            if (count_ff != '0) begin
               count_in = count_ff - COUNT_BITS'(1);
               status   = csq_pkg::ST_ACQUIRED;
            end else if (!full) begin
               total_in = total_ff + LEN_BITS'(1);
               status   = csq_pkg::ST_QUEUED;
            end
         end
         csq_pkg::OP_SIGNAL: begin
            if (hit_any) begin
               total_in = total_ff - LEN_BITS'(1);
               status   = csq_pkg::ST_WOKE;
            end else begin
               if (count_ff != '1) count_in = count_ff + COUNT_BITS'(1);
               status = csq_pkg::ST_RAISED;
            end
         end
         csq_pkg::OP_EXPIRE: begin
            status = hit_any ? csq_pkg::ST_TIMEOUT : csq_pkg::ST_SIGNALLED;
         end
         csq_pkg::OP_RESUME: begin
            if (hit_any) total_in = total_ff - LEN_BITS'(1);
            status = hit_any ? csq_pkg::ST_TIMEOUT : csq_pkg::ST_SIGNALLED;
         end
         csq_pkg::OP_INIT: begin
            count_in = COUNT_BITS'(csr_ff);
            total_in = '0;
            status   = csq_pkg::ST_INIT;
         end
         default: status = csq_pkg::ST_REFUSED;
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = RSP_W'({total_in, count_in, woken, status});
      end else begin
         count_in = count_ff;
         total_in = total_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= '0;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) csr_ff <= csr_wdata;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[tb/semaphore_checker.sv]
// Watches the request and response streams, predicts each semaphore reply and compares.
`default_nettype none

module semaphore_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [15:0] req_tdata,   // opcode, requester_id
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // status, woken_id, count_now, queue_length
   input  wire logic        csr_we,
   input  wire logic [15:0] csr_wdata,
   output int               failures,
   output int               outstanding
);

   localparam int          SLOTS     = 16;
   localparam logic [15:0] COUNT_TOP = 16'hFFFF;

   typedef struct {
      logic [2:0]  status;
      logic [7:0]  woken_id;
      logic [15:0] count_now;
      logic [4:0]  queue_length;
   } sem_reply_type;

   logic [15:0]   start_count_q;
   logic [15:0]   count_q;
   logic [7:0]    slot_id [SLOTS];
   logic          slot_expired [SLOTS];
   int            slot_total;
   sem_reply_type expected_replies [$];

   task automatic clear_slots();
      for (int i = 0; i < SLOTS; i++) begin
         slot_id[i]      = '0;
         slot_expired[i] = 1'b0;
      end
      slot_total = 0;
   endtask

   // take one waiter out and close the gap behind it
   task automatic remove_slot(input int pos);
      for (int j = pos; j + 1 < slot_total; j++) begin
         slot_id[j]      = slot_id[j+1];
         slot_expired[j] = slot_expired[j+1];
      end
      slot_total--;
      slot_id[slot_total]      = '0;
      slot_expired[slot_total] = 1'b0;
   endtask

   task automatic apply_semaphore_op(input logic [2:0] op, input logic [7:0] id,
                                     output sem_reply_type r);
      int hit;
      hit        = -1;
      r.status   = csq_pkg::ST_REFUSED;
      r.woken_id = '0;
      case (op)
         csq_pkg::OP_WAIT: begin
            if (count_q != 0) begin
               count_q  = count_q - 16'd1;
               r.status = csq_pkg::ST_ACQUIRED;
            end else if (slot_total < SLOTS) begin
               slot_id[slot_total]      = id;
               slot_expired[slot_total] = 1'b0;
               slot_total++;
               r.status = csq_pkg::ST_QUEUED;
            end
         end
         csq_pkg::OP_SIGNAL: begin
            for (int i = 0; i < slot_total; i++)
               if (hit < 0 && !slot_expired[i]) hit = i;
            if (hit >= 0) begin
               r.woken_id = slot_id[hit];
               remove_slot(hit);
               r.status = csq_pkg::ST_WOKE;
            end else begin
               if (count_q != COUNT_TOP) count_q = count_q + 16'd1;
               r.status = csq_pkg::ST_RAISED;
            end
         end
         csq_pkg::OP_EXPIRE: begin
            for (int i = 0; i < slot_total; i++)
               if (hit < 0 && !slot_expired[i] && slot_id[i] == id) hit = i;
            if (hit >= 0) slot_expired[hit] = 1'b1;
            r.status = (hit >= 0) ? csq_pkg::ST_TIMEOUT : csq_pkg::ST_SIGNALLED;
         end
         csq_pkg::OP_RESUME: begin
            for (int i = 0; i < slot_total; i++)
               if (hit < 0 && slot_id[i] == id) hit = i;
            if (hit >= 0) remove_slot(hit);
            r.status = (hit >= 0) ? csq_pkg::ST_TIMEOUT : csq_pkg::ST_SIGNALLED;
         end
         csq_pkg::OP_INIT: begin
            count_q = start_count_q;
            clear_slots();
            r.status = csq_pkg::ST_INIT;
         end
         default: r.status = csq_pkg::ST_REFUSED;
      endcase
      r.count_now    = count_q;
      r.queue_length = 5'(slot_total);
   endtask

   task automatic check_field(input string name, input int want, input int seen);
      if (want != seen) begin
         $error("%s: expected %0d, got %0d", name, want, seen);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      sem_reply_type want;
      sem_reply_type made;
      if (reset) begin
         failures      = 0;
         start_count_q = '0;
         count_q       = '0;
         clear_slots();
         expected_replies.delete();
      end else begin
         if (csr_we) start_count_q = csr_wdata;
         // response first: a reply in this cycle belongs to an earlier transfer
         if (rsp_tvalid && rsp_tready) begin
            if (expected_replies.size() == 0) begin
               $error("reply 0x%08h with no request outstanding", rsp_tdata);
               failures++;
            end else begin
               want = expected_replies.pop_front();
               check_field("status", want.status, rsp_tdata[2:0]);
               check_field("woken_id", want.woken_id, rsp_tdata[10:3]);
               check_field("count_now", want.count_now, rsp_tdata[26:11]);
               check_field("queue_length", want.queue_length, rsp_tdata[31:27]);
            end
         end
         if (req_tvalid && req_tready) begin
            apply_semaphore_op(req_tdata[2:0], req_tdata[10:3], made);
            expected_replies.push_back(made);
         end
      end
      outstanding = expected_replies.size();
   end

endmodule

`default_nettype wire

[tb/testbench.sv]
// Stimulus, clock, reset and verdict for the counting semaphore wait queue.
`default_nettype none

module testbench;

   localparam int ITEM_TARGET = 1320;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [15:0] csr_wdata = '0;

   int failures;
   int outstanding;
   int items_sent = 0;
   int hold_token = 0;
   bit gaps_on = 1'b1;
   logic [7:0] id_pool [4];

   always #4 clock = ~clock;

   counting_semaphore_wait_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   semaphore_checker u_sem_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_we      (csr_we),
      .csr_wdata   (csr_wdata),
      .failures    (failures),
      .outstanding (outstanding)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] pick_id();
      if ($urandom_range(0, 4) == 0) return 8'($urandom_range(0, 255));
      return id_pool[$urandom_range(0, 3)];
   endfunction

   function automatic logic [2:0] pick_op();
      int r;
      r = $urandom_range(0, 99);
      if (r < 34) return csq_pkg::OP_WAIT;
      if (r < 62) return csq_pkg::OP_SIGNAL;
      if (r < 78) return csq_pkg::OP_EXPIRE;
      if (r < 95) return csq_pkg::OP_RESUME;
      if (r < 97) return csq_pkg::OP_INIT;
      return 3'($urandom_range(5, 7));   // undefined opcodes
   endfunction

   task automatic issue(input logic [2:0] op, input logic [7:0] id);
      int gap;
      req_tdata  <= {5'd0, id, op};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender goes quiet until every reply is back
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_start_count(input logic [15:0] value);
      drain();
      csr_wdata <= value;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
   endtask

   // response side: random stalls in phases, plus a long hold on request
   initial begin : rsp_sink
      int stall_left;
      int phase_left;
      int hold_seen;
      bit calm;
      stall_left = 0;
      phase_left = 0;
      hold_seen  = 0;
      calm       = 1'b0;
      forever begin
         @(posedge clock);
         if (phase_left == 0) begin
            calm       = ($urandom_range(0, 3) == 0);
            phase_left = $urandom_range(50, 300);
         end
         phase_left--;
         if (hold_token != hold_seen) begin
            hold_seen  = hold_token;
            stall_left = 64;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 25) stall_left = pick_gap();
         end
      end
   end

   initial begin : stimulus
      int kind;
      int n;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: count at zero after reset
      issue(csq_pkg::OP_SIGNAL, 8'h00);
      issue(csq_pkg::OP_WAIT,   8'h00);
      issue(csq_pkg::OP_WAIT,   8'hFF);
      issue(csq_pkg::OP_WAIT,   8'hFF);       // repeated id
      issue(csq_pkg::OP_WAIT,   8'h5A);
      issue(csq_pkg::OP_EXPIRE, 8'hFF);
      issue(csq_pkg::OP_EXPIRE, 8'hFF);       // marks the second copy
      issue(csq_pkg::OP_EXPIRE, 8'hFF);       // nothing left unmarked
      issue(csq_pkg::OP_SIGNAL, 8'h00);       // skips expired entries
      issue(csq_pkg::OP_SIGNAL, 8'h00);       // only expired left, count rises
      issue(csq_pkg::OP_RESUME, 8'hFF);
      issue(csq_pkg::OP_RESUME, 8'h33);       // absent
      issue(3'd5, 8'hA5);
      issue(3'd6, 8'h5A);
      issue(3'd7, 8'hFF);
      write_start_count(16'hFFFF);
      issue(csq_pkg::OP_INIT,   8'h00);       // clears the remaining expired entry
      issue(csq_pkg::OP_SIGNAL, 8'h00);       // saturates
      issue(csq_pkg::OP_WAIT,   8'h81);
      write_start_count(16'h0000);
      issue(csq_pkg::OP_INIT,   8'h00);

      // random scenarios
      for (int scen = 0; items_sent < ITEM_TARGET; scen++) begin
         foreach (id_pool[i]) id_pool[i] = 8'($urandom_range(0, 255));
         gaps_on = ($urandom_range(0, 3) != 0);
         if (scen % 4 == 3) begin
            case ($urandom_range(0, 5))
               0:       write_start_count(16'h0000);
               1:       write_start_count(16'hFFFF);
               2:       write_start_count(16'($urandom_range(0, 65535)));
               default: write_start_count(16'($urandom_range(0, 3)));
            endcase
         end else if (scen % 9 == 4) begin
            drain();
         end
         // hold the response side off while requests keep coming
         if (scen == 1 || scen % 17 == 8) begin
            hold_token <= hold_token + 1;
            gaps_on = 1'b0;
         end
         kind = (scen == 0) ? 0 : $urandom_range(0, 9);
         if (kind <= 2) begin
            // fill the queue to near or past full, then work it down
            write_start_count(16'd0);
            issue(csq_pkg::OP_INIT, pick_id());
            n = $urandom_range(15, 22);
            repeat (n) issue(csq_pkg::OP_WAIT, pick_id());
            n = $urandom_range(15, 40);
            repeat (n) issue(pick_op(), pick_id());
         end else if (kind == 3) begin
            write_start_count(16'hFFFF - 16'($urandom_range(0, 2)));
            issue(csq_pkg::OP_INIT, pick_id());
            repeat (5) issue(csq_pkg::OP_SIGNAL, pick_id());
            repeat (3) issue(csq_pkg::OP_WAIT, pick_id());
         end else begin
            n = $urandom_range(20, 60);
            repeat (n) issue(pick_op(), pick_id());
         end
      end

      drain();
      repeat (4) @(posedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin : watchdog
      #(8 * 1000000);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

`default_nettype wire
